>>> rtl/core/ufmc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ufmc_pkg
// Shared constants and types for the union-find maze carver: grid limits,
// register map, result status codes, find selectors and sequencer states.
// ----------------------------------------------------------------------------
package ufmc_pkg;

    // Grid limits and field widths
    localparam int MAX_SIDE   = 16;
    localparam int CELL_COUNT = MAX_SIDE * MAX_SIDE;
    localparam int CELL_W     = $clog2(CELL_COUNT);
    localparam int SIDE_W     = 5;
    localparam int WALL_W     = 10;
    localparam int STATUS_W   = 2;

    // Configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [ADDR_W-3:0] REG_GRID_SIDE = '0;
    localparam logic [SIDE_W-1:0] GRID_SIDE_RST = SIDE_W'(16);

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_REMOVED  = 2'd0,
        STAT_JOINED   = 2'd1,
        STAT_REFUSED  = 2'd2,
        STAT_FINISHED = 2'd3
    } t_status;

    // Which find the sequencer is running
    typedef enum logic [1:0] {
        FIND_A    = 2'd0,
        FIND_B    = 2'd1,
        FIND_ZERO = 2'd2,
        FIND_LAST = 2'd3
    } t_find;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_WALK,
        ST_COMPRESS,
        ST_UNION,
        ST_DONE
    } t_state;

endpackage : ufmc_pkg
`default_nettype wire

>>> rtl/core/union_find_maze_carver_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// union_find_maze_carver_top
// Carves a square maze by randomized Kruskal: each wall word names a wall,
// a union-find store with path compression decides whether it is removed.
//
// Usage:
//  - Input channel (i_valid / o_stall / i_wall_number): one wall word per
//    item. A word is taken when i_valid is high and o_stall is low.
//  - Output channel (o_valid / i_stall / o_wall_echo, o_status, o_maze_done):
//    exactly one result word per input word, in order. The result sits in an
//    output register and holds while i_stall is high; the next input word is
//    taken while that result still waits.
//  - APB port: register 0 (byte address 0) is grid_side, cells per side,
//    clamped to 2..16 when used. Write it only while the block is idle.
//  - Sequence: a decode step, then four finds (first cell, second cell,
//    top-left, bottom-right). Each find walks the parent chain and then
//    compresses the walked path, all through the one read port and one write
//    port of the parent memory; a merge follows the second find when the roots
//    differ, and the result load comes last. Refused words run only the last
//    two finds and finished words none.
//  - Reset (synchronous, i_rst_n low): parent store reads as identity via
//    per-entry valid bits, finished flag clears, grid_side returns to 16.
//    No clearing pass is needed; words are taken right after reset.
// ----------------------------------------------------------------------------
module union_find_maze_carver_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // input channel
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [ufmc_pkg::WALL_W-1:0]    i_wall_number,
    // output channel
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [ufmc_pkg::WALL_W-1:0]         o_wall_echo,
    output logic [ufmc_pkg::STATUS_W-1:0]       o_status,
    output logic                                o_maze_done,
    // configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ufmc_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [ufmc_pkg::DATA_W-1:0]    pwdata,
    output logic [ufmc_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);
    import ufmc_pkg::*;

    // Sequencer and item registers
    t_state              r_state, n_state;
    t_find               r_find, n_find;
    t_status             r_status, n_status;
    logic                r_done, n_done;
    logic                r_finished, n_finished;
    logic [WALL_W-1:0]   r_wall;
    logic [CELL_W-1:0]   r_b, n_b;
    logic [CELL_W-1:0]   r_last, n_last;
    logic [CELL_W-1:0]   r_cur, n_cur;
    logic [CELL_W-1:0]   r_start, n_start;
    logic [CELL_W-1:0]   r_walk, n_walk;
    logic [CELL_W-1:0]   r_root, n_root;
    logic [CELL_W-1:0]   r_root_a, n_root_a;
    logic [CELL_W-1:0]   r_root_zero, n_root_zero;
    logic [SIDE_W-1:0]   r_grid_side;

    // Output register
    logic                r_out_valid;
    logic [WALL_W-1:0]   r_out_wall;
    t_status             r_out_status;
    logic                r_out_done;
    logic                out_free;
    logic                load_out;

    // Parent memory and its port
    logic [CELL_W-1:0]   mem [CELL_COUNT];
    logic                r_mem_vld [CELL_COUNT];
    logic [CELL_W-1:0]   rd_addr;
    logic [CELL_W-1:0]   r_rd_addr;
    logic [CELL_W-1:0]   r_rd_data;
    logic                r_rd_vld;
    logic                mem_we;
    logic [CELL_W-1:0]   mem_wa;
    logic [CELL_W-1:0]   mem_wd;
    logic                fwd_hit;
    logic [CELL_W-1:0]   parent;

    // Decode signals
    logic [SIDE_W-1:0]   side;
    logic [2*SIDE_W-1:0] side_sq;
    logic [WALL_W:0]     wall_ext;
    logic [WALL_W:0]     wall_lim;
    logic [WALL_W:0]     down_lim;
    logic [WALL_W-1:0]   wall_m1;
    logic [WALL_W-1:0]   cell_p1;
    logic [CELL_W-1:0]   dec_a;
    logic [CELL_W-1:0]   dec_b;
    logic [CELL_W-1:0]   dec_last;
    logic                in_range;
    logic                right_hit;
    logic                dec_ok;
    logic                apb_wr;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    assign apb_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_side <= GRID_SIDE_RST;
        end else if (apb_wr && paddr[ADDR_W-1:2] == REG_GRID_SIDE) begin
            r_grid_side <= pwdata[SIDE_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[ADDR_W-1:2] == REG_GRID_SIDE) begin
            prdata = DATA_W'(r_grid_side);
        end
    end

    // ------------------------------------------------------------------
    // Wall decode: clamp the side, bound the wall, locate both cells
    // ------------------------------------------------------------------
    always_comb begin
        if (r_grid_side < SIDE_W'(2)) begin
            side = SIDE_W'(2);
        end else if (r_grid_side > SIDE_W'(MAX_SIDE)) begin
            side = SIDE_W'(MAX_SIDE);
        end else begin
            side = r_grid_side;
        end
    end

    assign side_sq  = (2*SIDE_W)'(side) * (2*SIDE_W)'(side);
    assign wall_ext = {1'b0, r_wall};
    assign wall_lim = {side_sq[WALL_W-1:0], 1'b0};
    assign down_lim = {(side_sq[WALL_W-1:0] - WALL_W'(side)), 1'b0};
    assign in_range = (r_wall != '0) && (wall_ext <= wall_lim);
    assign wall_m1  = r_wall - WALL_W'(1);
    assign cell_p1  = {1'b0, wall_m1[WALL_W-1:1]} + WALL_W'(1);
    assign dec_a    = wall_m1[CELL_W:1];
    assign dec_b    = r_wall[0] ? dec_a + CELL_W'(1) : dec_a + CELL_W'(side);
    assign dec_last = CELL_W'(side_sq - (2*SIDE_W)'(1));

    // Flag a right wall on the last column: cell + 1 is a multiple of side
    always_comb begin
        right_hit = 1'b0;
        for (int k = 1; k <= MAX_SIDE; k++) begin
            if ((WALL_W'(k) * WALL_W'(side)) == cell_p1) begin
                right_hit = 1'b1;
            end
        end
    end

    assign dec_ok = in_range && (r_wall[0] ? !right_hit : (wall_ext <= down_lim));

    // ------------------------------------------------------------------
    // Parent memory: one read port and one write port, registered read,
    // write-to-read forwarding
    // ------------------------------------------------------------------
    assign fwd_hit = mem_we && (mem_wa == rd_addr);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= fwd_hit ? mem_wd : mem[rd_addr];
        r_rd_addr <= rd_addr;
    end

    // Valid bits: an unwritten entry is its own parent
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CELL_COUNT; i++) begin
                r_mem_vld[i] <= 1'b0;
            end
            r_rd_vld <= 1'b0;
        end else begin
            if (mem_we) begin
                r_mem_vld[mem_wa] <= 1'b1;
            end
            r_rd_vld <= fwd_hit || r_mem_vld[rd_addr];
        end
    end

    assign parent = r_rd_vld ? r_rd_data : r_rd_addr;

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_state = r_finished ? ST_DONE : ST_WALK;
            end
            ST_WALK: begin
                if (parent == r_cur) begin
                    n_state = ST_COMPRESS;
                end
            end
            ST_COMPRESS: begin
                if (r_walk == r_root) begin
                    case (r_find)
                        FIND_B:    n_state = (r_root_a == r_root) ? ST_WALK : ST_UNION;
                        FIND_LAST: n_state = ST_DONE;
                        default:   n_state = ST_WALK;
                    endcase
                end
            end
            ST_UNION: begin
                n_state = ST_WALK;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: datapath and memory control
    // ------------------------------------------------------------------
    always_comb begin
        n_find      = r_find;
        n_status    = r_status;
        n_done      = r_done;
        n_finished  = r_finished;
        n_b         = r_b;
        n_last      = r_last;
        n_cur       = r_cur;
        n_start     = r_start;
        n_walk      = r_walk;
        n_root      = r_root;
        n_root_a    = r_root_a;
        n_root_zero = r_root_zero;
        rd_addr     = r_cur;
        mem_we      = 1'b0;
        mem_wa      = r_walk;
        mem_wd      = r_root;
        load_out    = 1'b0;
        o_stall     = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
            end
            ST_DECODE: begin
                n_b    = dec_b;
                n_last = dec_last;
                if (r_finished) begin
                    n_status = STAT_FINISHED;
                    n_done   = 1'b1;
                end else if (!dec_ok) begin
                    // refused wall: only the done check remains
                    n_status = STAT_REFUSED;
                    n_find   = FIND_ZERO;
                    n_cur    = '0;
                    n_start  = '0;
                    rd_addr  = '0;
                end else begin
                    n_find  = FIND_A;
                    n_cur   = dec_a;
                    n_start = dec_a;
                    rd_addr = dec_a;
                end
            end
            ST_WALK: begin
                // climb until a cell is its own parent
                if (parent == r_cur) begin
                    n_root  = r_cur;
                    n_walk  = r_start;
                    rd_addr = r_start;
                end else begin
                    n_cur   = parent;
                    rd_addr = parent;
                end
            end
            ST_COMPRESS: begin
                if (r_walk != r_root) begin
                    // point the walked cell at the root, advance
                    mem_we  = 1'b1;
                    mem_wa  = r_walk;
                    mem_wd  = r_root;
                    n_walk  = parent;
                    rd_addr = parent;
                end else begin
                    case (r_find)
                        FIND_A: begin
                            n_root_a = r_root;
                            n_find   = FIND_B;
                            n_cur    = r_b;
                            n_start  = r_b;
                            rd_addr  = r_b;
                        end
                        FIND_B: begin
                            if (r_root_a == r_root) begin
                                n_status = STAT_JOINED;
                                n_find   = FIND_ZERO;
                                n_cur    = '0;
                                n_start  = '0;
                                rd_addr  = '0;
                            end
                        end
                        FIND_ZERO: begin
                            n_root_zero = r_root;
                            n_find      = FIND_LAST;
                            n_cur       = r_last;
                            n_start     = r_last;
                            rd_addr     = r_last;
                        end
                        FIND_LAST: begin
                            n_done = (r_root_zero == r_root);
                        end
                        default: begin
                            n_find = FIND_A;
                        end
                    endcase
                end
            end
            ST_UNION: begin
                // hang the first root under the second
                mem_we   = 1'b1;
                mem_wa   = r_root_a;
                mem_wd   = r_root;
                n_status = STAT_REMOVED;
                n_find   = FIND_ZERO;
                n_cur    = '0;
                n_start  = '0;
                rd_addr  = '0;
            end
            ST_DONE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    if (r_done) begin
                        n_finished = 1'b1;
                    end
                end
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_finished <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_finished <= n_finished;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid) begin
            r_wall <= i_wall_number;
        end
        r_find      <= n_find;
        r_status    <= n_status;
        r_done      <= n_done;
        r_b         <= n_b;
        r_last      <= n_last;
        r_cur       <= n_cur;
        r_start     <= n_start;
        r_walk      <= n_walk;
        r_root      <= n_root;
        r_root_a    <= n_root_a;
        r_root_zero <= n_root_zero;
    end

    // Output register: load a finished word, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_wall   <= r_wall;
            r_out_status <= r_status;
            r_out_done   <= r_done;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_wall_echo = r_out_wall;
    assign o_status    = r_out_status;
    assign o_maze_done = r_out_done;

`ifndef SYNTH
    // A taken word blocks the input until its result is loaded
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken while sequencer busy");

    // Once finished, the maze stays finished
    a_fin_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |=> r_finished)
        else $error("finished flag dropped");

    // A finished result always reports the maze as done
    a_fin_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == STAT_FINISHED) |-> o_maze_done)
        else $error("finished status without maze_done");

    // The parent store is never written while idle
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !mem_we)
        else $error("parent write while idle");
`endif

endmodule : union_find_maze_carver_top
`default_nettype wire

>>> test/ufmc_carve_checker.sv
// ----------------------------------------------------------------------------
// ufmc_carve_checker
// Watches the wall and result channels and the APB port of the maze carver.
// Keeps its own union-find store, side register and finished flag, works out
// the result of every accepted wall word and compares it with the next
// result word field by field.
// ----------------------------------------------------------------------------
module ufmc_carve_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // wall channel
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic [ufmc_pkg::WALL_W-1:0]     i_in_wall,
    // result channel
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic [ufmc_pkg::WALL_W-1:0]     i_out_wall,
    input  logic [ufmc_pkg::STATUS_W-1:0]   i_out_status,
    input  logic                            i_out_done,
    // configuration port
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic                            i_pready,
    input  logic [ufmc_pkg::ADDR_W-1:0]     i_paddr,
    input  logic [ufmc_pkg::DATA_W-1:0]     i_pwdata,
    // status toward the testbench top
    output int                              o_fail_count,
    output int                              o_pending
);
    import ufmc_pkg::*;

    typedef struct packed {
        logic [WALL_W-1:0] wall;
        t_status           status;
        logic              done;
    } t_carve_result;

    logic [CELL_W-1:0] cell_link [CELL_COUNT];
    logic [SIDE_W-1:0] side_reg;
    logic              maze_joined;
    t_carve_result     pending_carves [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Find the root of a cell, then point every cell on the walked path at it
    function automatic logic [CELL_W-1:0] find_root(input logic [CELL_W-1:0] c);
        logic [CELL_W-1:0] root;
        logic [CELL_W-1:0] walk;
        logic [CELL_W-1:0] next_cell;
        int                steps;
        root  = c;
        steps = 0;
        while (cell_link[root] != root && steps < CELL_COUNT) begin
            root = cell_link[root];
            steps++;
        end
        walk  = c;
        steps = 0;
        while (walk != root && steps < CELL_COUNT) begin
            next_cell       = cell_link[walk];
            cell_link[walk] = root;
            walk            = next_cell;
            steps++;
        end
        return root;
    endfunction

    // Carve one wall word and update the store
    function automatic t_carve_result carve_wall(input logic [WALL_W-1:0] w);
        t_carve_result     r;
        int unsigned       wv;
        int unsigned       n;
        int unsigned       last_cell;
        int unsigned       cell_a;
        int unsigned       cell_b;
        logic              legal;
        logic [CELL_W-1:0] root_a;
        logic [CELL_W-1:0] root_b;
        logic [CELL_W-1:0] root_first;
        logic [CELL_W-1:0] root_last;
        wv = w;
        n  = side_reg;
        if (n < 2) n = 2;
        if (n > MAX_SIDE) n = MAX_SIDE;
        last_cell = n * n - 1;
        r.wall    = w;
        if (maze_joined) begin
            r.status = STAT_FINISHED;
            r.done   = 1'b1;
            return r;
        end
        // decode: odd is a right wall, even a down wall
        legal  = 1'b0;
        cell_a = 0;
        cell_b = 0;
        if (wv >= 1 && wv <= 2 * n * n) begin
            if (wv % 2 == 1) begin
                if ((wv + 1) % (2 * n) != 0) begin
                    cell_a = (wv + 1) / 2 - 1;
                    cell_b = cell_a + 1;
                    legal  = 1'b1;
                end
            end else if (wv <= 2 * n * (n - 1)) begin
                cell_a = wv / 2 - 1;
                cell_b = cell_a + n;
                legal  = 1'b1;
            end
        end
        if (!legal) begin
            r.status = STAT_REFUSED;
        end else begin
            root_a = find_root(CELL_W'(cell_a));
            root_b = find_root(CELL_W'(cell_b));
            if (root_a == root_b) begin
                r.status = STAT_JOINED;
            end else begin
                cell_link[root_a] = root_b;
                r.status          = STAT_REMOVED;
            end
        end
        // corner test also compresses both paths
        root_first = find_root('0);
        root_last  = find_root(CELL_W'(last_cell));
        r.done     = (root_first == root_last);
        if (r.done) maze_joined = 1'b1;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_carve_result want_r;
        if (!i_rst_n) begin
            // reset the store to identity
            for (int i = 0; i < CELL_COUNT; i++) cell_link[i] = CELL_W'(i);
            side_reg    = GRID_SIDE_RST;
            maze_joined = 1'b0;
            pending_carves.delete();
        end else begin
            // track writes to the side register
            if (i_psel && i_penable && i_pwrite && i_pready
                    && i_paddr[ADDR_W-1:2] == REG_GRID_SIDE) begin
                side_reg = i_pwdata[SIDE_W-1:0];
            end
            // compare a result word with the oldest expectation
            if (i_out_valid && !i_out_stall) begin
                if (pending_carves.size() == 0) begin
                    $display("%0t: result word wall %0d with nothing expected",
                             $time, i_out_wall);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want_r = pending_carves.pop_front();
                    if (i_out_wall !== want_r.wall) begin
                        $display("%0t: wall_echo expected %0d, got %0d",
                                 $time, want_r.wall, i_out_wall);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_out_status !== want_r.status) begin
                        $display("%0t: status of wall %0d expected %0d, got %0d",
                                 $time, want_r.wall, want_r.status, i_out_status);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_out_done !== want_r.done) begin
                        $display("%0t: maze_done of wall %0d expected %0d, got %0d",
                                 $time, want_r.wall, want_r.done, i_out_done);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            // predict an accepted wall word
            if (i_in_valid && !i_in_stall) begin
                pending_carves.push_back(carve_wall(i_in_wall));
            end
        end
        o_pending = pending_carves.size();
    end

endmodule : ufmc_carve_checker

>>> test/union_find_maze_carver_top_tb.sv
// ----------------------------------------------------------------------------
// union_find_maze_carver_top_tb
// Drives wall words and side settings into the maze carver and gives the
// verdict. A short directed run covers refused, joined and removed walls at
// the side extremes; random phases with varied idling on both channels
// follow, and a last 2x2 phase finishes the maze. The checker beside the
// block predicts and compares every result word.
// ----------------------------------------------------------------------------
module union_find_maze_carver_top_tb;
    import ufmc_pkg::*;

    localparam int QUIET_LIMIT = 20000;
    localparam logic [ADDR_W-1:0] GRID_SIDE_ADDR = {REG_GRID_SIDE, 2'b00};

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_valid       = 1'b0;
    logic              o_stall;
    logic [WALL_W-1:0] i_wall_number = '0;
    logic              o_valid;
    logic              i_stall       = 1'b0;
    logic [WALL_W-1:0] o_wall_echo;
    logic [STATUS_W-1:0] o_status;
    logic              o_maze_done;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [ADDR_W-1:0] paddr         = '0;
    logic [DATA_W-1:0] pwdata        = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int          fail_count;
    int          pending;
    int unsigned stall_pct   = 0;
    int unsigned gen_side    = 16;
    int          quiet_cycles = 0;

    union_find_maze_carver_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_wall_number (i_wall_number),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_wall_echo   (o_wall_echo),
        .o_status      (o_status),
        .o_maze_done   (o_maze_done),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    ufmc_carve_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_wall    (i_wall_number),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_wall   (o_wall_echo),
        .i_out_status (o_status),
        .i_out_done   (o_maze_done),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Stall the result channel at random
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Send one wall word after a random gap, hold it until taken
    task automatic send_wall(input logic [WALL_W-1:0] w, input int unsigned idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_wall_number <= w;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Hold off the sender until every result word has come
    task automatic drain();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    // Write the side register while the block is idle
    task automatic set_side(input logic [SIDE_W-1:0] side);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= GRID_SIDE_ADDR;
        pwdata  <= DATA_W'(side);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        gen_side = (side < 2) ? 2 : (side > MAX_SIDE) ? MAX_SIDE : side;
    endtask

    // Mostly legal walls of the current grid, some borders and noise
    function automatic logic [WALL_W-1:0] random_wall(input int unsigned n);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 80) return WALL_W'($urandom_range(1, 2 * n * n));
        if (pick < 88) return WALL_W'($urandom_range(0, 1023));
        if (pick < 94) return WALL_W'(2 * n * $urandom_range(1, n) - 1);
        return WALL_W'(2 * n * (n - 1) + 2 * $urandom_range(1, n));
    endfunction

    // Random phase with the given idling on both sides
    task automatic run_random(input int count, input int unsigned idle_pct,
                              input int unsigned stall_v);
        stall_pct = stall_v;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(49) == 0) drain();
            send_wall(random_wall(gen_side), idle_pct);
        end
    endtask

    initial begin : stimulus
        // 16x16: borders, out of range, then removals and a repeat
        int unsigned wide_walls [12] = '{0, 1023, 512, 31, 511, 513,
                                         1, 1, 2, 480, 481, 509};
        // 2x2 and clamped side: refused and already-joined walls only
        int unsigned tiny_walls [6]  = '{3, 6, 9, 8, 1, 2};
        int unsigned low_walls [3]   = '{7, 0, 1};
        // every inner wall of a 2x2 grid, so the maze must finish
        int unsigned close_walls [4] = '{1, 2, 4, 5};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (wide_walls[k]) send_wall(WALL_W'(wide_walls[k]), 0);
        send_wall(WALL_W'(3), 0);
        set_side(SIDE_W'(0));
        foreach (tiny_walls[k]) send_wall(WALL_W'(tiny_walls[k]), 0);
        set_side(SIDE_W'(1));
        foreach (low_walls[k]) send_wall(WALL_W'(low_walls[k]), 0);

        // random phases over the idling mixes
        set_side(SIDE_W'(31));
        run_random(110, 0, 0);
        set_side(SIDE_W'(16));
        run_random(110, 47, 0);
        set_side(SIDE_W'($urandom_range(3, 15)));
        run_random(100, 0, 47);
        set_side(SIDE_W'(16));
        run_random(100, 32, 32);

        // finish the maze, then words answered as done
        set_side(SIDE_W'(2));
        stall_pct = 0;
        foreach (close_walls[k]) send_wall(WALL_W'(close_walls[k]), 0);
        run_random(40, 20, 20);

        drain();
        stall_pct = 0;
        repeat (64) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule : union_find_maze_carver_top_tb

>>> filelist.f
rtl/core/ufmc_pkg.sv
rtl/core/union_find_maze_carver_top.sv
test/ufmc_carve_checker.sv
test/union_find_maze_carver_top_tb.sv
